// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPRQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wprq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WPRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wprq assertion failed");

`endif

// File: rtl/wprq_pkg.sv
// ----------------------------------------------------------------------------
// wprq_pkg
// Shared types and constants of the weighted priority ready queue.
// ----------------------------------------------------------------------------
package wprq_pkg;

  localparam int NUM_PRIO    = 4;
  localparam int PRIO_W      = 2;
  localparam int REQ_PRIO_W  = 3;
  localparam int TASK_OUT_W  = 32;
  localparam int TOTAL_OUT_W = 7;
  localparam int WEIGHT_W    = 8;
  localparam int STATUS_W    = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [PRIO_W-1:0]   prio_t;

  // Weight reset values, priority 0 in the lowest slot.
  localparam weight_t [NUM_PRIO-1:0] WEIGHT_RESET = {8'd1, 8'd2, 8'd4, 8'd8};

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_t;

  // Outcome of the pop arbitration.
  typedef struct packed {
    logic  found;
    logic  restart;
    prio_t prio;
  } pick_t;

endpackage

// File: rtl/wprq_if.sv
// ----------------------------------------------------------------------------
// wprq_in_if / wprq_out_if
// Valid/ready channels carrying requests into and results out of the queue.
// ----------------------------------------------------------------------------
interface wprq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic [wprq_pkg::REQ_PRIO_W-1:0]      priority_req;
  logic [wprq_pkg::TASK_OUT_W-1:0]      task_data;

  modport source (output valid, output operation, output priority_req,
                  output task_data, input ready);
  modport sink   (input valid, input operation, input priority_req,
                  input task_data, output ready);
endinterface

interface wprq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [wprq_pkg::STATUS_W-1:0]        status;
  logic [wprq_pkg::TASK_OUT_W-1:0]      task_out;
  logic [wprq_pkg::PRIO_W-1:0]          served_priority;
  logic [wprq_pkg::TOTAL_OUT_W-1:0]     total_count;

  modport source (output valid, output status, output task_out,
                  output served_priority, output total_count, input ready);
  modport sink   (input valid, input status, input task_out,
                  input served_priority, input total_count, output ready);
endinterface

// File: rtl/wprq_ram.sv
// ----------------------------------------------------------------------------
// wprq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wprq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wprq_pick.sv
// ----------------------------------------------------------------------------
// wprq_pick
// Pop arbitration: weighted scan over the four priorities with batch restart.
// ----------------------------------------------------------------------------
module wprq_pick (
  input  wprq_pkg::weight_t [wprq_pkg::NUM_PRIO-1:0] served_cnt,
  input  wprq_pkg::weight_t [wprq_pkg::NUM_PRIO-1:0] weight,
  input  logic [wprq_pkg::NUM_PRIO-1:0]              nonempty,
  output wprq_pkg::pick_t                            pick
);

  localparam int NUM_PRIO = wprq_pkg::NUM_PRIO;
  localparam int PRIO_W   = wprq_pkg::PRIO_W;

  logic [NUM_PRIO-1:0] qualify;
  logic                qual_any;
  logic [PRIO_W-1:0]   qual_prio;
  logic [PRIO_W-1:0]   first_prio;

  always_comb begin
    qual_prio  = '0;
    first_prio = '0;
    for (int q = 0; q < NUM_PRIO; q++) begin
      qualify[q] = nonempty[q] && (served_cnt[q] < weight[q]);
    end
    qual_any = |qualify;
    // Scan from the highest number down so that the lowest-numbered one wins.
    for (int q = NUM_PRIO - 1; q >= 0; q--) begin
      if (qualify[q]) begin
        qual_prio = PRIO_W'(q);
      end
      if (nonempty[q]) begin
        first_prio = PRIO_W'(q);
      end
    end
    pick.found   = |nonempty;
    pick.restart = !qual_any;
    pick.prio    = qual_any ? qual_prio : first_prio;
  end

endmodule

// File: rtl/weighted_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// weighted_priority_ready_queue
// Four priority FIFOs of task words sharing one task memory, with a weighted
// pop and an APB-style port for the four weights.
// ----------------------------------------------------------------------------
// A push is decided in the cycle of its transfer; a pop also passes through the
// read state, because the task word leaves the synchronous task memory in the
// cycle after its address is presented. Each result then passes through a one-entry
// result stage into the output register, and the request port stays closed while
// the result stage is occupied or a pop read is under way. With the sink ready, the
// next request is taken only once the previous result has left the result stage.
// A stalled sink can hold one result in the output register and one in the result
// stage, after which further requests wait. Pointers, fill levels and served
// counters sit in flops; the task words are never cleared, since a slot is only
// read after it was written.
module weighted_priority_ready_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wprq_in_if.sink                             in_ch,
  wprq_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wprq_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [wprq_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [wprq_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int NUM_PRIO    = wprq_pkg::NUM_PRIO;
  localparam int PRIO_W      = wprq_pkg::PRIO_W;
  localparam int TASK_OUT_W  = wprq_pkg::TASK_OUT_W;
  localparam int TOTAL_OUT_W = wprq_pkg::TOTAL_OUT_W;
  localparam int CFG_DATA_W  = wprq_pkg::CFG_DATA_W;
  localparam int STATUS_W    = wprq_pkg::STATUS_W;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W       = $clog2(NUM_PRIO * QUEUE_DEPTH + 1);
  localparam int STORE_W     = (TASK_WIDTH < TASK_OUT_W) ? TASK_WIDTH : TASK_OUT_W;
  localparam int ADDR_W      = PRIO_W + PTR_W;
  localparam int RAM_DEPTH   = NUM_PRIO * (2 ** PTR_W);

  // State.
  wprq_pkg::fsm_t                              state_r, state_nxt;
  logic [PTR_W-1:0]                            rptr_r [NUM_PRIO];
  logic [PTR_W-1:0]                            rptr_nxt [NUM_PRIO];
  logic [PTR_W-1:0]                            wptr_r [NUM_PRIO];
  logic [PTR_W-1:0]                            wptr_nxt [NUM_PRIO];
  logic [FILL_W-1:0]                           fill_r [NUM_PRIO];
  logic [FILL_W-1:0]                           fill_nxt [NUM_PRIO];
  wprq_pkg::weight_t [NUM_PRIO-1:0]            cnt_r, cnt_nxt;
  wprq_pkg::weight_t [NUM_PRIO-1:0]            weight_r, weight_nxt;
  logic [TOT_W-1:0]                            total_r, total_nxt;

  // Result stage and output register.
  logic                                        pend_valid_r, pend_valid_nxt;
  logic [STATUS_W-1:0]                         pend_status_r, pend_status_nxt;
  logic [TASK_OUT_W-1:0]                       pend_task_r, pend_task_nxt;
  logic [PRIO_W-1:0]                           pend_served_r, pend_served_nxt;
  logic [TOTAL_OUT_W-1:0]                      pend_total_r, pend_total_nxt;
  logic                                        out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]                         out_status_r, out_status_nxt;
  logic [TASK_OUT_W-1:0]                       out_task_r, out_task_nxt;
  logic [PRIO_W-1:0]                           out_served_r, out_served_nxt;
  logic [TOTAL_OUT_W-1:0]                      out_total_r, out_total_nxt;

  // Datapath.
  logic                                        in_ready;
  logic                                        accept;
  logic                                        cfg_write;
  logic [PRIO_W-1:0]                           cfg_index;
  logic [PRIO_W-1:0]                           push_prio;
  logic [NUM_PRIO-1:0]                         nonempty;
  wprq_pkg::pick_t                             pick;
  logic                                        ram_we;
  logic [ADDR_W-1:0]                           ram_waddr;
  logic [ADDR_W-1:0]                           ram_raddr;
  logic [STORE_W-1:0]                          ram_rdata;

  wprq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (RAM_DEPTH)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.task_data[STORE_W-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int q = 0; q < NUM_PRIO; q++) begin
      nonempty[q] = (fill_r[q] != '0);
    end
  end

  wprq_pick u_pick (
    .served_cnt (cnt_r),
    .weight     (weight_r),
    .nonempty   (nonempty),
    .pick       (pick)
  );

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_index  = cfg_paddr[PRIO_W+1:2];
  assign cfg_prdata = CFG_DATA_W'(weight_r[cfg_index]);

  // Priorities above three all go to queue three, the lowest priority.
  assign push_prio = in_ch.priority_req[PRIO_W] ? PRIO_W'(NUM_PRIO - 1)
                                                : in_ch.priority_req[PRIO_W-1:0];

  assign in_ready = (state_r == wprq_pkg::FSM_IDLE) && !pend_valid_r;
  assign accept   = in_ch.valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    rptr_nxt        = rptr_r;
    wptr_nxt        = wptr_r;
    fill_nxt        = fill_r;
    cnt_nxt         = cnt_r;
    weight_nxt      = weight_r;
    total_nxt       = total_r;
    pend_valid_nxt  = pend_valid_r;
    pend_status_nxt = pend_status_r;
    pend_task_nxt   = pend_task_r;
    pend_served_nxt = pend_served_r;
    pend_total_nxt  = pend_total_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_task_nxt    = out_task_r;
    out_served_nxt  = out_served_r;
    out_total_nxt   = out_total_r;
    ram_we          = 1'b0;
    ram_waddr       = {push_prio, wptr_r[push_prio]};
    ram_raddr       = {pick.prio, rptr_r[pick.prio]};

    if (cfg_write) begin
      weight_nxt[cfg_index] = cfg_pwdata[wprq_pkg::WEIGHT_W-1:0];
    end

    // Output side: retire a taken result, then refill from the result stage.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_valid_r && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pend_status_r;
      out_task_nxt   = pend_task_r;
      out_served_nxt = pend_served_r;
      out_total_nxt  = pend_total_r;
      pend_valid_nxt = 1'b0;
    end

    case (state_r)
      wprq_pkg::FSM_IDLE: begin
        if (accept) begin
          pend_status_nxt = wprq_pkg::STATUS_OK;
          pend_task_nxt   = '0;
          pend_served_nxt = '0;
          if (in_ch.operation == wprq_pkg::OP_PUSH) begin
            pend_valid_nxt = 1'b1;
            if (fill_r[push_prio] == FILL_W'(QUEUE_DEPTH)) begin
              pend_status_nxt = wprq_pkg::STATUS_FULL;
            end else begin
              ram_we              = 1'b1;
              wptr_nxt[push_prio] = (wptr_r[push_prio] == PTR_W'(QUEUE_DEPTH - 1))
                                    ? '0 : wptr_r[push_prio] + PTR_W'(1);
              fill_nxt[push_prio] = fill_r[push_prio] + FILL_W'(1);
              total_nxt           = total_r + TOT_W'(1);
            end
          end else if (pick.found) begin
            // The task word arrives from memory next cycle.
            state_nxt            = wprq_pkg::FSM_READ;
            pend_served_nxt      = pick.prio;
            rptr_nxt[pick.prio]  = (rptr_r[pick.prio] == PTR_W'(QUEUE_DEPTH - 1))
                                   ? '0 : rptr_r[pick.prio] + PTR_W'(1);
            fill_nxt[pick.prio]  = fill_r[pick.prio] - FILL_W'(1);
            total_nxt            = total_r - TOT_W'(1);
            if (pick.restart) begin
              cnt_nxt            = '0;
              cnt_nxt[pick.prio] = wprq_pkg::WEIGHT_W'(1);
            end else begin
              cnt_nxt[pick.prio] = cnt_r[pick.prio] + wprq_pkg::WEIGHT_W'(1);
            end
          end else begin
            pend_valid_nxt  = 1'b1;
            pend_status_nxt = wprq_pkg::STATUS_EMPTY;
            cnt_nxt         = '0;
          end
          pend_total_nxt = TOTAL_OUT_W'(total_nxt);
        end
      end
      wprq_pkg::FSM_READ: begin
        pend_task_nxt  = TASK_OUT_W'(ram_rdata);
        pend_valid_nxt = 1'b1;
        state_nxt      = wprq_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = wprq_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wprq_pkg::FSM_IDLE;
      cnt_r        <= '0;
      weight_r     <= wprq_pkg::WEIGHT_RESET;
      total_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int q = 0; q < NUM_PRIO; q++) begin
        rptr_r[q] <= '0;
        wptr_r[q] <= '0;
        fill_r[q] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      weight_r     <= weight_nxt;
      total_r      <= total_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      rptr_r       <= rptr_nxt;
      wptr_r       <= wptr_nxt;
      fill_r       <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_task_r   <= pend_task_nxt;
    pend_served_r <= pend_served_nxt;
    pend_total_r  <= pend_total_nxt;
    out_status_r  <= out_status_nxt;
    out_task_r    <= out_task_nxt;
    out_served_r  <= out_served_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.task_out        = out_task_r;
  assign out_ch.served_priority = out_served_r;
  assign out_ch.total_count     = out_total_r;

endmodule

// File: rtl/wprq_checker.sv
// ----------------------------------------------------------------------------
// wprq_checker
// Port-level checks on the result channel of the weighted priority queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wprq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [wprq_pkg::STATUS_W-1:0]    out_status,
  input logic [wprq_pkg::TASK_OUT_W-1:0]  out_task,
  input logic [wprq_pkg::PRIO_W-1:0]      out_served,
  input logic [wprq_pkg::TOTAL_OUT_W-1:0] out_total
);

  // A result that is not taken stays offered.
  `WPRQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // An empty pop means nothing at all is queued.
  `WPRQ_ASSERT_SAME(a_empty_total, out_valid && out_status == wprq_pkg::STATUS_EMPTY, out_total == '0)

  // Only a successful pop carries a task word or a serving priority.
  `WPRQ_ASSERT_SAME(a_fail_zero, out_valid && out_status != wprq_pkg::STATUS_OK, out_task == '0 && out_served == '0)

  `WPRQ_ASSERT_SAME(a_served_ok, out_valid && out_served != '0, out_status == wprq_pkg::STATUS_OK)

endmodule

bind weighted_priority_ready_queue wprq_checker u_wprq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_task   (out_ch.task_out),
  .out_served (out_ch.served_priority),
  .out_total  (out_ch.total_count)
);
